>>> design/two_level_branch_predictor_defines.svh
// Assertion macros for the two-level branch predictor.
`ifndef TWO_LEVEL_BRANCH_PREDICTOR_DEFINES_SVH
`define TWO_LEVEL_BRANCH_PREDICTOR_DEFINES_SVH
// Implication checked on the same clock edge.
`define TLBP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("two_level_branch_predictor: assertion failed");
// Implication checked on the following clock edge.
`define TLBP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("two_level_branch_predictor: assertion failed");
`endif

>>> design/tlbp_pkg.sv
// Shared constants and types of the two-level branch predictor.
package tlbp_pkg;
    localparam int BTB_ENTRIES = 32;
    localparam int IDX_W       = $clog2(BTB_ENTRIES);
    localparam int MAX_HISTORY = 8;
    localparam int ROW_SIZE    = 1 << MAX_HISTORY;
    localparam int TAG_W       = 32 - 2 - IDX_W;
    localparam int PRV_AW      = IDX_W + MAX_HISTORY;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_HIST_LEN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAG_LEN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CNT_RESET  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GLOBAL_HIST = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GLOBAL_TBL = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SHARE_MODE = 3'd5;

    localparam logic [1:0] SHARE_PC_LOW  = 2'd1;
    localparam logic [1:0] SHARE_PC_HIGH = 2'd2;
    localparam logic [1:0] CNT_INIT      = 2'd1;
    localparam logic [1:0] CNT_MAX       = 2'd3;

    typedef struct packed {
        logic latch;
        logic look;
        logic alloc;
        logic fill_wr;
        logic clear_wr;
        logic step;
    } t_cmd;

    typedef struct packed {
        logic is_update;
        logic hit;
        logic gtable;
        logic fill_last;
        logic clear_last;
    } t_status;
endpackage

>>> design/two_level_branch_predictor.sv
// Top level of the two-level adaptive branch predictor with target buffer.
// A word is issued by raising i_start while o_busy is low; i_mode selects a
// predict request or a resolved branch update, with the other inputs sampled
// at that same edge. Each word yields one result word, held on the o_ ports
// for exactly one cycle while o_done is high; the receiver cannot stall it.
// A predict or an update that hits passes through the lookup state, where the
// counter memory read is registered, and the data state, which registers the
// result; a new word is taken only once the block is idle again.
// An update that misses allocates the entry and repeats the lookup, and with
// private counter tables first refills the entry's row of 256 counters.
// Configuration is written through i_cfg_valid, i_cfg_index and i_cfg_data,
// always ready; the user must write it only while the block is idle, as the
// block does not enforce this. After reset it clears its counter memories
// with o_busy high before the first word; configuration is taken then.
`include "two_level_branch_predictor_defines.svh"
module two_level_branch_predictor (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    output logic                            o_busy,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [tlbp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tlbp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_mode,
    input  logic [31:0]                     i_branch_pc,
    input  logic [31:0]                     i_actual_target,
    input  logic                            i_actual_taken,
    input  logic [31:0]                     i_earlier_prediction,
    output logic                            o_done,
    output logic                            o_predict_taken,
    output logic [31:0]                     o_predicted_target,
    output logic [31:0]                     o_branch_count,
    output logic [31:0]                     o_flush_count
);
    tlbp_pkg::t_cmd    cmd;
    tlbp_pkg::t_status status;

    assign o_cfg_ready = 1'b1;

    tlbp_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (o_busy)
    );

    tlbp_dp u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (cmd),
        .o_status             (status),
        .i_cfg_valid          (i_cfg_valid),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data),
        .i_mode               (i_mode),
        .i_branch_pc          (i_branch_pc),
        .i_actual_target      (i_actual_target),
        .i_actual_taken       (i_actual_taken),
        .i_earlier_prediction (i_earlier_prediction),
        .o_done               (o_done),
        .o_predict_taken      (o_predict_taken),
        .o_predicted_target   (o_predicted_target),
        .o_branch_count       (o_branch_count),
        .o_flush_count        (o_flush_count)
    );

    `TLBP_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, i_start && !o_busy, o_busy)
    `TLBP_ASSERT_NEXT(a_done_single, i_clk, i_rst_n, o_done, !o_done)
    `TLBP_ASSERT_NOW(a_done_after_busy, i_clk, i_rst_n, o_done, $past(o_busy))
endmodule

>>> design/tlbp_ctrl.sv
// Control state machine of the two-level branch predictor.
module tlbp_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  tlbp_pkg::t_status i_status,
    output tlbp_pkg::t_cmd  o_cmd,
    output logic            o_busy
);
    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_LOOK  = 5'b00100,
        S_FILL  = 5'b01000,
        S_DATA  = 5'b10000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear_wr = 1'b1;
                if (i_status.clear_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.latch = 1'b1;
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                o_cmd.look = 1'b1;
                if (i_status.is_update && !i_status.hit) begin
                    o_cmd.alloc = 1'b1;
                    n_state = i_status.gtable ? S_LOOK : S_FILL;
                end else begin
                    n_state = S_DATA;
                end
            end
            S_FILL: begin
                o_cmd.fill_wr = 1'b1;
                if (i_status.fill_last) n_state = S_LOOK;
            end
            S_DATA: begin
                o_cmd.step = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);
endmodule

>>> design/tlbp_dp.sv
// Datapath of the two-level branch predictor: BTB, histories, counter memories.
module tlbp_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  tlbp_pkg::t_cmd                 i_cmd,
    output tlbp_pkg::t_status              o_status,
    input  logic                           i_cfg_valid,
    input  logic [tlbp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [tlbp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_mode,
    input  logic [31:0]                    i_branch_pc,
    input  logic [31:0]                    i_actual_target,
    input  logic                           i_actual_taken,
    input  logic [31:0]                    i_earlier_prediction,
    output logic                           o_done,
    output logic                           o_predict_taken,
    output logic [31:0]                    o_predicted_target,
    output logic [31:0]                    o_branch_count,
    output logic [31:0]                    o_flush_count
);
    localparam int IW = tlbp_pkg::IDX_W;
    localparam int HW = tlbp_pkg::MAX_HISTORY;
    localparam int TW = tlbp_pkg::TAG_W;
    localparam int AW = tlbp_pkg::PRV_AW;

    logic [3:0] r_hist_len;
    logic [4:0] r_tag_len;
    logic [1:0] r_cnt_reset;
    logic       r_ghist;
    logic       r_gtable;
    logic [1:0] r_share;

    logic        r_mode;
    logic [31:0] r_pc;
    logic [31:0] r_target_in;
    logic        r_taken;
    logic [31:0] r_earlier;

    logic [tlbp_pkg::BTB_ENTRIES-1:0] r_valid;
    logic [TW-1:0] r_tag [tlbp_pkg::BTB_ENTRIES];
    logic [31:0]   r_target [tlbp_pkg::BTB_ENTRIES];
    logic [HW-1:0] r_ehist [tlbp_pkg::BTB_ENTRIES];
    logic [HW-1:0] r_shist;

    logic [1:0] mem_prv [1 << AW];
    logic [1:0] mem_shr [tlbp_pkg::ROW_SIZE];
    logic [1:0] r_prv_rd, r_shr_rd;
    logic [AW-1:0] r_paddr;
    logic [HW-1:0] r_saddr;
    logic [AW-1:0] r_sweep;

    logic [31:0] r_updates, r_flushes;
    logic        r_done, r_p_taken;
    logic [31:0] r_p_target;

    logic [IW-1:0] idx;
    logic [TW-1:0] pc_tag, tmask;
    logic [HW-1:0] hmask, hsel, haddr, hnew;
    logic          hit;
    logic [1:0]    cnt, cnt_next;
    logic [31:0]   fall;
    logic          upd_step;
    logic          prv_we, shr_we;
    logic [AW-1:0] prv_wa;
    logic [HW-1:0] shr_wa;
    logic [1:0]    prv_wd, shr_wd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist_len  <= 4'd1;
            r_tag_len   <= 5'd0;
            r_cnt_reset <= tlbp_pkg::CNT_INIT;
            r_ghist     <= 1'b0;
            r_gtable    <= 1'b0;
            r_share     <= 2'd0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                tlbp_pkg::CFG_HIST_LEN:    r_hist_len  <= i_cfg_data[3:0];
                tlbp_pkg::CFG_TAG_LEN:     r_tag_len   <= i_cfg_data;
                tlbp_pkg::CFG_CNT_RESET:   r_cnt_reset <= i_cfg_data[1:0];
                tlbp_pkg::CFG_GLOBAL_HIST: r_ghist     <= i_cfg_data[0];
                tlbp_pkg::CFG_GLOBAL_TBL:  r_gtable    <= i_cfg_data[0];
                tlbp_pkg::CFG_SHARE_MODE:  r_share     <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    assign idx    = r_pc[2 +: IW];
    assign pc_tag = r_pc[31 -: TW];
    assign fall   = r_pc + 32'd4;

    always_comb begin
        for (int i = 0; i < TW; i++) tmask[i] = (5'(i) < r_tag_len);
        for (int i = 0; i < HW; i++) hmask[i] = (4'(i) < r_hist_len);
    end

    assign hit  = r_valid[idx] && (((r_tag[idx] ^ pc_tag) & tmask) == '0);
    assign hsel = (r_ghist ? r_shist : r_ehist[idx]) & hmask;

    always_comb begin
        haddr = hsel;
        if (r_share == tlbp_pkg::SHARE_PC_LOW) begin
            haddr = hsel ^ (r_pc[2 +: HW] & hmask);
        end else if (r_share == tlbp_pkg::SHARE_PC_HIGH) begin
            haddr = hsel ^ (r_pc[16 +: HW] & hmask);
        end
    end

    assign cnt = r_gtable ? r_shr_rd : r_prv_rd;

    always_comb begin
        if (r_taken) begin
            cnt_next = (cnt == tlbp_pkg::CNT_MAX) ? cnt : cnt + 2'd1;
        end else begin
            cnt_next = (cnt == 2'd0) ? cnt : cnt - 2'd1;
        end
    end

    assign hnew     = {hsel[HW-2:0], r_taken} & hmask;
    assign upd_step = i_cmd.step && r_mode;

    always_comb begin
        prv_we = i_cmd.clear_wr || i_cmd.fill_wr || (upd_step && !r_gtable);
        shr_we = i_cmd.clear_wr || (upd_step && r_gtable);
        prv_wa = r_paddr;
        prv_wd = cnt_next;
        shr_wa = r_saddr;
        shr_wd = cnt_next;
        if (i_cmd.clear_wr) begin
            prv_wa = r_sweep;
            prv_wd = tlbp_pkg::CNT_INIT;
            shr_wa = r_sweep[HW-1:0];
            shr_wd = tlbp_pkg::CNT_INIT;
        end else if (i_cmd.fill_wr) begin
            prv_wa = {idx, r_sweep[HW-1:0]};
            prv_wd = r_cnt_reset;
        end
    end

    always_ff @(posedge i_clk) begin
        if (prv_we) mem_prv[prv_wa] <= prv_wd;
        if (i_cmd.look) r_prv_rd <= mem_prv[{idx, hsel}];
    end

    always_ff @(posedge i_clk) begin
        if (shr_we) mem_shr[shr_wa] <= shr_wd;
        if (i_cmd.look) r_shr_rd <= mem_shr[haddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_mode      <= i_mode;
            r_pc        <= i_branch_pc;
            r_target_in <= i_actual_target;
            r_taken     <= i_actual_taken;
            r_earlier   <= i_earlier_prediction;
        end
        if (i_cmd.look) begin
            r_paddr <= {idx, hsel};
            r_saddr <= haddr;
        end
        if (i_cmd.alloc) r_tag[idx] <= pc_tag;
        if (upd_step) r_target[idx] <= r_target_in;
        if (i_cmd.step) begin
            r_p_taken  <= !r_mode && hit && cnt[1];
            r_p_target <= r_mode ? 32'd0 : ((hit && cnt[1]) ? r_target[idx] : fall);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_shist   <= '0;
            r_sweep   <= '0;
            r_updates <= '0;
            r_flushes <= '0;
            r_done    <= 1'b0;
            for (int i = 0; i < tlbp_pkg::BTB_ENTRIES; i++) r_ehist[i] <= '0;
        end else begin
            r_done <= i_cmd.step;
            if (i_cmd.latch) begin
                r_sweep <= '0;
            end else if (i_cmd.clear_wr || i_cmd.fill_wr) begin
                r_sweep <= r_sweep + AW'(1);
            end
            if (i_cmd.alloc) begin
                r_valid[idx] <= 1'b1;
                if (!r_ghist) r_ehist[idx] <= '0;
            end
            if (upd_step) begin
                r_updates <= r_updates + 32'd1;
                if (r_earlier != (r_taken ? r_target_in : fall)) begin
                    r_flushes <= r_flushes + 32'd1;
                end
                if (r_ghist) begin
                    r_shist <= hnew;
                end else begin
                    r_ehist[idx] <= hnew;
                end
            end
        end
    end

    assign o_status.is_update  = r_mode;
    assign o_status.hit        = hit;
    assign o_status.gtable     = r_gtable;
    assign o_status.fill_last  = (r_sweep[HW-1:0] == '1);
    assign o_status.clear_last = (r_sweep == '1);

    assign o_done             = r_done;
    assign o_predict_taken    = r_p_taken;
    assign o_predicted_target = r_p_target;
    assign o_branch_count     = r_updates;
    assign o_flush_count      = r_flushes;
endmodule
